// ----- rtl/sorted_timer_queue_macros.svh -----
// Assertion macros for the sorted timer queue.
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define STQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define STQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/stq_pkg.sv -----
package stq_pkg;

  localparam int Depth = 16;
  localparam int IdBits = 16;
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int TickW = 48;

  typedef struct packed {
    logic        req_type;
    logic [47:0] now_ticks;
    logic [15:0] timer_id;
    logic [7:0]  owner;
    logic [47:0] expiry_ticks;
    logic [47:0] interval_ticks;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] fired_id;
    logic [7:0]  fired_owner;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CANCEL_SCAN,
    ST_REMOVE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_REJECT,
    ST_FIRE_CHECK,
    ST_FIRE,
    ST_WAIT_OUT
  } state_t;

  typedef enum logic [1:0] {
    INS_NEW,
    INS_REARM
  } ins_src_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic      load_req;
    logic      clr_ptr;
    logic      inc_ptr;
    logic      shift_down_step;
    logic      shift_up_step;
    logic      write_slot;
    logic      inc_count;
    logic      dec_count;
    ins_src_t  ins_src;
    logic      latch_head;
    logic      clr_fires;
    logic      inc_fires;
    logic      set_ptr_top;
    logic      dec_ptr;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic req_type;
    logic is_cancel;
    logic full;
    logic empty;
    logic ptr_at_end;
    logic ptr_at_last;
    logic id_match;
    logic slot_le_key;
    logic ptr_eq_pos;
    logic head_due;
    logic fires_done;
    logic head_periodic;
  } stat_t;

endpackage

// ----- rtl/stq_datapath.sv -----
module stq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::in_item_t  in_item,
  input  stq_pkg::cmd_t      cmd,
  output stq_pkg::stat_t     stat,
  output logic [15:0]        head_id,
  output logic [7:0]         head_owner,
  output logic [15:0]        req_id,
  output logic [7:0]         req_owner
);
  import stq_pkg::*;

  logic [IdBits-1:0] id_mem_r [Depth];
  logic [7:0]        own_mem_r [Depth];
  logic [TickW-1:0]  exp_mem_r [Depth];
  logic [TickW-1:0]  ivl_mem_r [Depth];

  in_item_t          req_r;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [CntW-1:0]   ptr_r, ptr_nxt;
  logic [CntW-1:0]   pos_r;
  logic [CntW-1:0]   fires_r, fires_nxt;
  logic [IdBits-1:0] h_id_r;
  logic [7:0]        h_own_r;
  logic [TickW-1:0]  h_ivl_r;
  logic [TickW-1:0]  key_exp;
  logic [IdBits-1:0] key_id;
  logic [7:0]        key_own;
  logic [TickW-1:0]  key_ivl;
  logic [TickW:0]    rearm_sum;
  logic [PtrW-1:0]   pidx;
  logic [PtrW-1:0]   pidx_m1;

  assign pidx = ptr_r[PtrW-1:0];
  assign pidx_m1 = pidx - PtrW'(1);
  assign rearm_sum = {1'b0, req_r.now_ticks} + {1'b0, h_ivl_r};

  always_comb begin
    if (cmd.ins_src == INS_REARM) begin
      key_id  = h_id_r;
      key_own = h_own_r;
      key_ivl = h_ivl_r;
      key_exp = rearm_sum[TickW] ? {TickW{1'b1}} : rearm_sum[TickW-1:0];
    end else begin
      key_id  = req_r.timer_id[IdBits-1:0];
      key_own = req_r.owner;
      key_ivl = req_r.interval_ticks;
      key_exp = req_r.expiry_ticks;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.inc_count) begin
      count_nxt = count_r + CntW'(1);
    end else if (cmd.dec_count) begin
      count_nxt = count_r - CntW'(1);
    end
    ptr_nxt = ptr_r;
    if (cmd.clr_ptr) begin
      ptr_nxt = '0;
    end else if (cmd.set_ptr_top) begin
      ptr_nxt = count_r;
    end else if (cmd.inc_ptr) begin
      ptr_nxt = ptr_r + CntW'(1);
    end else if (cmd.dec_ptr) begin
      ptr_nxt = ptr_r - CntW'(1);
    end
    fires_nxt = fires_r;
    if (cmd.clr_fires) begin
      fires_nxt = '0;
    end else if (cmd.inc_fires) begin
      fires_nxt = fires_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      fires_r <= '0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      fires_r <= fires_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_item;
    end
    if (cmd.set_ptr_top) begin
      pos_r <= ptr_r;
    end
    if (cmd.latch_head) begin
      h_id_r  <= id_mem_r[0];
      h_own_r <= own_mem_r[0];
      h_ivl_r <= ivl_mem_r[0];
    end
    if (cmd.shift_down_step) begin
      id_mem_r[pidx]  <= id_mem_r[pidx + PtrW'(1)];
      own_mem_r[pidx] <= own_mem_r[pidx + PtrW'(1)];
      exp_mem_r[pidx] <= exp_mem_r[pidx + PtrW'(1)];
      ivl_mem_r[pidx] <= ivl_mem_r[pidx + PtrW'(1)];
    end else if (cmd.shift_up_step) begin
      id_mem_r[pidx]  <= id_mem_r[pidx_m1];
      own_mem_r[pidx] <= own_mem_r[pidx_m1];
      exp_mem_r[pidx] <= exp_mem_r[pidx_m1];
      ivl_mem_r[pidx] <= ivl_mem_r[pidx_m1];
    end else if (cmd.write_slot) begin
      id_mem_r[pidx]  <= key_id;
      own_mem_r[pidx] <= key_own;
      exp_mem_r[pidx] <= key_exp;
      ivl_mem_r[pidx] <= key_ivl;
    end
  end

  always_comb begin
    stat.req_type      = req_r.req_type;
    stat.is_cancel     = (req_r.expiry_ticks == '0) && (req_r.interval_ticks == '0);
    stat.full          = (count_r == CntW'(Depth));
    stat.empty         = (count_r == '0);
    stat.ptr_at_end    = (ptr_r >= count_r);
    stat.ptr_at_last   = (ptr_r + CntW'(1) >= count_r);
    stat.id_match      = (id_mem_r[pidx] == req_r.timer_id[IdBits-1:0]);
    stat.slot_le_key   = (exp_mem_r[pidx] <= key_exp);
    stat.ptr_eq_pos    = (ptr_r == pos_r);
    stat.head_due      = (exp_mem_r[0] <= req_r.now_ticks);
    stat.fires_done    = (fires_r == CntW'(Depth));
    stat.head_periodic = (h_ivl_r != '0);
  end

  assign head_id    = 16'(h_id_r);
  assign head_owner = h_own_r;
  assign req_id     = 16'(req_r.timer_id[IdBits-1:0]);
  assign req_owner  = req_r.owner;

endmodule

// ----- rtl/stq_ctrl.sv -----
`include "sorted_timer_queue_macros.svh"
module stq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_busy,
  input  stq_pkg::stat_t      stat,
  output stq_pkg::cmd_t       cmd,
  output logic                emit_reject,
  output logic                emit_fire
);
  import stq_pkg::*;

  state_t state_r, state_nxt;
  logic   any_r, any_nxt;
  logic   rearm_r, rearm_nxt;

  // The top level owns the output register; this block only asks for an
  // emit and waits while that register is full.

  always_comb begin
    state_nxt = state_r;
    any_nxt   = any_r;
    rearm_nxt = rearm_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECIDE;
          any_nxt   = 1'b0;
          rearm_nxt = 1'b0;
        end
      end
      ST_DECIDE: begin
        if (!stat.req_type) begin
          state_nxt = ST_FIRE_CHECK;
        end else if (stat.is_cancel) begin
          state_nxt = ST_CANCEL_SCAN;
        end else if (stat.full) begin
          state_nxt = ST_REJECT;
        end else begin
          state_nxt = ST_INS_SCAN;
        end
      end
      ST_CANCEL_SCAN: begin
        if (stat.ptr_at_end) begin
          state_nxt = ST_FIRE_CHECK;
        end else if (stat.id_match) begin
          state_nxt = ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        if (stat.ptr_at_last) begin
          if (rearm_r) begin
            state_nxt = stat.head_periodic ? ST_INS_SCAN : ST_FIRE;
          end else begin
            state_nxt = ST_FIRE_CHECK;
          end
        end
      end
      ST_INS_SCAN: begin
        if (stat.ptr_at_end || !stat.slot_le_key) begin
          state_nxt = ST_INS_SHIFT;
        end
      end
      ST_INS_SHIFT: begin
        if (stat.ptr_eq_pos) begin
          state_nxt = rearm_r ? ST_FIRE : ST_FIRE_CHECK;
        end
      end
      ST_REJECT: begin
        if (!out_busy) begin
          any_nxt   = 1'b1;
          state_nxt = ST_FIRE_CHECK;
        end
      end
      ST_FIRE_CHECK: begin
        if (stat.empty || stat.fires_done || !stat.head_due) begin
          state_nxt = any_r ? ST_WAIT_OUT : ST_IDLE;
        end else begin
          rearm_nxt = 1'b1;
          state_nxt = ST_REMOVE;
        end
      end
      ST_FIRE: begin
        if (!out_busy) begin
          any_nxt   = 1'b1;
          rearm_nxt = 1'b0;
          state_nxt = ST_FIRE_CHECK;
        end
      end
      ST_WAIT_OUT: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.ins_src = rearm_r ? INS_REARM : INS_NEW;
    in_ready = 1'b0;
    emit_reject = 1'b0;
    emit_fire = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_req = in_valid;
        cmd.clr_ptr = 1'b1;
        cmd.clr_fires = 1'b1;
      end
      ST_CANCEL_SCAN: begin
        if (!stat.ptr_at_end && !stat.id_match) begin
          cmd.inc_ptr = 1'b1;
        end
      end
      ST_REMOVE: begin
        if (stat.ptr_at_last) begin
          cmd.dec_count = 1'b1;
          cmd.clr_ptr = 1'b1;
        end else begin
          cmd.shift_down_step = 1'b1;
          cmd.inc_ptr = 1'b1;
        end
      end
      ST_INS_SCAN: begin
        if (stat.ptr_at_end || !stat.slot_le_key) begin
          cmd.set_ptr_top = 1'b1;
        end else begin
          cmd.inc_ptr = 1'b1;
        end
      end
      ST_INS_SHIFT: begin
        if (stat.ptr_eq_pos) begin
          cmd.write_slot = 1'b1;
          cmd.inc_count = 1'b1;
          cmd.clr_ptr = 1'b1;
        end else begin
          cmd.shift_up_step = 1'b1;
          cmd.dec_ptr = 1'b1;
        end
      end
      ST_REJECT: begin
        emit_reject = !out_busy;
      end
      ST_FIRE_CHECK: begin
        cmd.latch_head = 1'b1;
        cmd.clr_ptr = 1'b1;
      end
      ST_FIRE: begin
        emit_fire = !out_busy;
        cmd.inc_fires = !out_busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      any_r   <= 1'b0;
      rearm_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      any_r   <= any_nxt;
      rearm_r <= rearm_nxt;
    end
  end

  `STQ_ASSERT_IMP(a_ready_only_idle, clk, rst_n, in_ready, state_r == ST_IDLE)
  `STQ_ASSERT_IMP(a_one_emit, clk, rst_n, emit_fire, !emit_reject)
  `STQ_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r == ST_DECIDE)

endmodule

// ----- rtl/sorted_timer_queue.sv -----
// Sorted timer queue: up to 16 timers held in ascending expiry order in four
// register arrays, walked by a single pointer. One item at a time is taken.
// An arm scans for its place and shifts the later timers up; a cancel scans
// for the id and shifts the later timers down. Each timer that fires is taken
// off the head and, when it is periodic, re-inserted. The work per item grows
// with the number of stored timers, output stalls add to it, and an item with
// results waits for the output register before the next is taken. Results
// leave through an output register; the last result of an item is marked once
// the item's firing pass has ended, by holding that result until it is known
// to be final.
module sorted_timer_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stq_pkg::out_item_t  out_data
);
  import stq_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic        emit_reject, emit_fire;
  logic [15:0] head_id, req_id;
  logic [7:0]  head_owner, req_owner;
  logic        held_r, held_nxt;
  out_item_t   held_item_r, held_item_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;
  logic        ctrl_busy;
  logic        idle_now;

  stq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .head_id    (head_id),
    .head_owner (head_owner),
    .req_id     (req_id),
    .req_owner  (req_owner)
  );

  // The controller sees the output stage as busy while the output register
  // holds a result and out_ready is low, so the register cannot take another.
  assign ctrl_busy = ov_r && !out_ready;

  stq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_busy    (ctrl_busy),
    .stat        (stat),
    .cmd         (cmd),
    .emit_reject (emit_reject),
    .emit_fire   (emit_fire)
  );

  assign idle_now = in_ready;

  always_comb begin
    held_nxt = held_r;
    held_item_nxt = held_item_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (emit_reject || emit_fire) begin
      if (held_r) begin
        ov_nxt = 1'b1;
        od_nxt = held_item_r;
      end
      held_nxt = 1'b1;
      held_item_nxt.status = emit_reject;
      held_item_nxt.fired_id = emit_reject ? req_id : head_id;
      held_item_nxt.fired_owner = emit_reject ? req_owner : head_owner;
      held_item_nxt.last = 1'b0;
    end else if (held_r && idle_now && !ctrl_busy) begin
      ov_nxt = 1'b1;
      od_nxt = held_item_r;
      od_nxt.last = 1'b1;
      held_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      held_r <= held_nxt;
      ov_r   <= ov_nxt;
    end
    held_item_r <= held_item_nxt;
    od_r        <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ----- tb/sorted_timer_queue_test.sv -----
`timescale 1ns / 100ps

module sorted_timer_queue_test;
  import stq_pkg::*;

  localparam logic [47:0] MaxTick = 48'hFFFF_FFFF_FFFF;
  localparam logic ReqTick = 1'b0;
  localparam logic ReqTimer = 1'b1;
  localparam logic StatFired = 1'b0;
  localparam logic StatRejected = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  sorted_timer_queue uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  logic [15:0] tq_id [Depth];
  logic [7:0] tq_owner [Depth];
  logic [47:0] tq_expiry [Depth];
  logic [47:0] tq_interval [Depth];
  int tq_count = 0;
  out_item_t pending_results[$];

  int mismatches = 0;
  int fired_seen = 0;
  int rejects_seen = 0;
  int items_sent = 0;
  int burst_left = 0;
  int hold_left = 0;
  logic [15:0] id_pool [12];
  logic [47:0] cur_time = '0;

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic in_item_t make_item(logic req, logic [47:0] now, logic [15:0] id,
                                         logic [7:0] own, logic [47:0] expiry,
                                         logic [47:0] interval);
    in_item_t it;
    it.req_type = req;
    it.now_ticks = now;
    it.timer_id = id;
    it.owner = own;
    it.expiry_ticks = expiry;
    it.interval_ticks = interval;
    return it;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i + 1 < tq_count; i++) begin
      tq_id[i] = tq_id[i + 1];
      tq_owner[i] = tq_owner[i + 1];
      tq_expiry[i] = tq_expiry[i + 1];
      tq_interval[i] = tq_interval[i + 1];
    end
    tq_count--;
  endfunction

  function automatic void place_timer(logic [15:0] id, logic [7:0] own,
                                      logic [47:0] expiry, logic [47:0] interval);
    int pos;
    pos = 0;
    while (pos < tq_count && tq_expiry[pos] <= expiry) pos++;
    for (int i = tq_count; i > pos; i--) begin
      tq_id[i] = tq_id[i - 1];
      tq_owner[i] = tq_owner[i - 1];
      tq_expiry[i] = tq_expiry[i - 1];
      tq_interval[i] = tq_interval[i - 1];
    end
    tq_id[pos] = id;
    tq_owner[pos] = own;
    tq_expiry[pos] = expiry;
    tq_interval[pos] = interval;
    tq_count++;
  endfunction

  function automatic void predict_timers(in_item_t it);
    out_item_t r;
    logic [48:0] next;
    logic [15:0] fid;
    logic [7:0] fown;
    logic [47:0] fivl;
    int fires;
    int produced;
    fires = 0;
    produced = 0;
    if (it.req_type == ReqTimer) begin
      if (it.expiry_ticks == '0 && it.interval_ticks == '0) begin
        for (int i = 0; i < tq_count; i++) begin
          if (tq_id[i] == it.timer_id) begin
            drop_timer(i);
            break;
          end
        end
      end else if (tq_count >= Depth) begin
        r = '{status: StatRejected, fired_id: it.timer_id, fired_owner: it.owner, last: 1'b0};
        pending_results.push_back(r);
        produced++;
      end else begin
        place_timer(it.timer_id, it.owner, it.expiry_ticks, it.interval_ticks);
      end
    end
    while (tq_count > 0 && fires < Depth && tq_expiry[0] <= it.now_ticks) begin
      fid = tq_id[0];
      fown = tq_owner[0];
      fivl = tq_interval[0];
      drop_timer(0);
      if (fivl != '0) begin
        next = {1'b0, it.now_ticks} + {1'b0, fivl};
        if (next[48]) next = {1'b0, MaxTick};
        place_timer(fid, fown, next[47:0], fivl);
      end
      r = '{status: StatFired, fired_id: fid, fired_owner: fown, last: 1'b0};
      pending_results.push_back(r);
      produced++;
      fires++;
    end
    if (produced > 0) pending_results[$].last = 1'b1;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timers(it);
    items_sent++;
    burst_left--;
  endtask

  task automatic test_fire_order();
    send_item(make_item(ReqTick, 48'd0, '0, '0, '0, '0));
    send_item(make_item(ReqTimer, 48'd1, 16'h0011, 8'h01, 48'd20, '0));
    send_item(make_item(ReqTimer, 48'd2, 16'h0022, 8'h02, 48'd20, '0));
    send_item(make_item(ReqTimer, 48'd10, 16'h0033, 8'h03, 48'd5, '0));
    send_item(make_item(ReqTick, 48'd20, 16'hFFFF, 8'hFF, MaxTick, MaxTick));
  endtask

  task automatic test_cancel();
    send_item(make_item(ReqTimer, 48'd21, 16'h0044, 8'h04, 48'd30, '0));
    send_item(make_item(ReqTimer, 48'd22, 16'h0044, 8'h05, 48'd30, '0));
    send_item(make_item(ReqTimer, 48'd23, 16'h0055, 8'h06, '0, '0));
    send_item(make_item(ReqTimer, 48'd24, 16'h0044, 8'h07, '0, '0));
    send_item(make_item(ReqTick, 48'd30, '0, '0, '0, '0));
  endtask

  task automatic test_full_store();
    for (int i = 0; i < Depth; i++)
      send_item(make_item(ReqTimer, 48'd1000, 16'h0100 + i[15:0], i[7:0], 48'd2000, '0));
    send_item(make_item(ReqTimer, 48'd2000, 16'hABCD, 8'hEE, 48'd2500, '0));
  endtask

  task automatic test_saturated_rearm();
    send_item(make_item(ReqTimer, MaxTick - 1, 16'hFFFF, 8'hFF, MaxTick, MaxTick));
    send_item(make_item(ReqTick, MaxTick, 16'hFFFF, 8'hFF, MaxTick, MaxTick));
    send_item(make_item(ReqTimer, MaxTick, 16'hFFFF, 8'h00, '0, '0));
    send_item(make_item(ReqTick, 48'd0, '0, '0, '0, '0));
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    for (int i = 0; i < 12; i++)
      send_item(make_item(ReqTimer, 48'd3000 + 48'(i), 16'($urandom()), 8'($urandom()),
                          48'd3000, '0));
  endtask

  task automatic test_random_traffic(int count);
    int pick;
    logic [15:0] id;
    logic [47:0] expiry;
    logic [47:0] interval;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) cur_time = rand48();
      else if (pick < 4) cur_time = 48'($urandom_range(0, 200));
      else cur_time = cur_time + 48'($urandom_range(0, 8));
      id = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 11)] : 16'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        send_item(make_item(ReqTick, cur_time, 16'($urandom()), 8'($urandom()), rand48(),
                            rand48()));
      end else if (pick < 48) begin
        send_item(make_item(ReqTimer, cur_time, id, 8'($urandom()), '0, '0));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 8) expiry = cur_time + 48'($urandom_range(0, 40));
        else if (pick < 9) expiry = rand48();
        else expiry = cur_time - 48'($urandom_range(0, 5));
        pick = $urandom_range(0, 9);
        if (pick < 6) interval = '0;
        else if (pick < 9) interval = 48'($urandom_range(1, 30));
        else interval = rand48();
        if (expiry == '0 && interval == '0) interval = 48'd1;
        send_item(make_item(ReqTimer, cur_time, id, 8'($urandom()), expiry, interval));
      end
    end
  endtask

  initial begin
    int mode;
    int phase_left;
    mode = 0;
    phase_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 2);
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_data.status == StatRejected) rejects_seen++;
      else fired_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d id %h owner %h last %0d",
                   out_data.status, out_data.fired_id, out_data.fired_owner, out_data.last);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.fired_id !== want.fired_id ||
            out_data.fired_owner !== want.fired_owner || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d id %h owner %h last %0d, got %0d %h %h %0d",
                     want.status, want.fired_id, want.fired_owner, want.last,
                     out_data.status, out_data.fired_id, out_data.fired_owner, out_data.last);
        end
      end
    end
  end

  initial begin
    #16000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int waited;
    for (int i = 0; i < 12; i++) id_pool[i] = 16'($urandom());
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_fire_order();
    test_cancel();
    test_full_store();
    test_saturated_rearm();
    test_backpressure();
    test_random_traffic(370);
    @(negedge clk) in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (800) @(posedge clk);
    if (pending_results.size() > 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("Sent %0d items; saw %0d firings and %0d rejected arms.",
             items_sent, fired_seen, rejects_seen);
    $display("Covered ordering, cancels, a full store, saturated re-arm and output stalls.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_datapath.sv
rtl/stq_ctrl.sv
rtl/sorted_timer_queue.sv
tb/sorted_timer_queue_test.sv
